[hw/rtl/sssp_pkg.sv]
`default_nettype none
package sssp_pkg;

	localparam int unsigned DEF_MAX_VERTICES = 64;
	localparam int unsigned DEF_MAX_EDGES    = 1024;
	localparam int unsigned DEF_WEIGHT_BITS  = 16;

	// widest vertex index and distance over the legal parameter ranges
	localparam int unsigned VMAX_W = 10;
	localparam int unsigned DMAX_W = 41;

	typedef struct packed {
		logic              init;
		logic [VMAX_W-1:0] start_idx;
		logic              start_ok;
		logic              visit;
		logic [VMAX_W-1:0] pick;
		logic              relax;
		logic [VMAX_W-1:0] dst;
		logic [DMAX_W-1:0] cand;
	} ctl_t;

	typedef struct packed {
		logic              found;
		logic [VMAX_W-1:0] idx;
		logic [DMAX_W-1:0] dval;
	} tok_t;

endpackage
`default_nettype wire

[hw/rtl/sssp_edge_mem.sv]
`default_nettype none
module sssp_edge_mem #(
	parameter int unsigned AW = 10,
	parameter int unsigned DW = 28
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/sssp_cell.sv]
`default_nettype none
module sssp_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned DW  = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              active,
	input  sssp_pkg::ctl_t    ctl,
	input  sssp_pkg::tok_t    tok_in,
	output sssp_pkg::tok_t    tok_out,
	output logic [DW-1:0]     best,
	output logic              reach
);
	import sssp_pkg::*;

	logic [DW-1:0] dist_q;
	logic          vis_q;
	logic          reach_q;
	tok_t          tok_q;
	logic          mine_dst;
	logic          take;
	logic          better;
	logic [DW-1:0] cand;

	assign cand     = ctl.cand[DW-1:0];
	assign mine_dst = ctl.relax && (ctl.dst == VMAX_W'(IDX));
	assign take     = mine_dst && !vis_q && (!reach_q || (cand < dist_q));
	// strict compare keeps the lower index on ties
	assign better   = active && !vis_q && reach_q &&
		(!tok_in.found || (DMAX_W'(dist_q) < tok_in.dval));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q   <= 1'b0;
			reach_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (ctl.init) begin
				vis_q   <= 1'b0;
				reach_q <= ctl.start_ok && (ctl.start_idx == VMAX_W'(IDX));
			end else begin
				if (ctl.visit && (ctl.pick == VMAX_W'(IDX))) begin
					vis_q <= 1'b1;
				end
				if (take) begin
					reach_q <= 1'b1;
				end
			end
			if (better) begin
				tok_q.found <= 1'b1;
				tok_q.idx   <= VMAX_W'(IDX);
				tok_q.dval  <= DMAX_W'(dist_q);
			end else begin
				tok_q <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			dist_q <= '0;
		end else if (take) begin
			dist_q <= cand;
		end
	end

	assign tok_out = tok_q;
	assign best    = dist_q;
	assign reach   = reach_q;
endmodule
`default_nettype wire

[hw/rtl/single_source_shortest_path.sv]
`default_nettype none
// channel   | signals                          | direction | payload
// ----------+----------------------------------+-----------+----------------------------
// request   | in_valid / in_stall              | in        | operation .. start_vertex
// result    | out_valid / out_stall            | out       | vertex_index .. last_vertex
// config    | cfg_valid / cfg_ready            | in        | cfg_data (vertex_count)
//
// Add-edge and clear requests are accepted back to back.
// A run goes, per round, through the round check, the min-token pass along the
// cell chain and the pick, then the edge-store sweep, for at most
// vertex_count-1 rounds, then gives one result per cycle while out_stall is low;
// in_stall is high meanwhile.
// Reset clears control state and the edge count; vertex_count resets to 64.
// out_stall holds the result register and the walk through the results; the sweep ignores it.
module single_source_shortest_path
	import sssp_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES,
	parameter int unsigned MAX_EDGES    = sssp_pkg::DEF_MAX_EDGES,
	parameter int unsigned WEIGHT_BITS  = sssp_pkg::DEF_WEIGHT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [5:0]  from_vertex,
	input  logic [5:0]  to_vertex,
	input  logic [15:0] edge_weight_in,
	input  logic [5:0]  start_vertex,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  vertex_index,
	output logic [21:0] distance,
	output logic        reachable,
	output logic        last_vertex,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam int unsigned VW  = $clog2(MAX_VERTICES);
	localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
	localparam int unsigned CW  = (NW > 7) ? NW : 7;
	localparam int unsigned DW  = WEIGHT_BITS + VW;
	localparam int unsigned XW  = DW + 22;
	localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
	localparam int unsigned MW  = 12 + WEIGHT_BITS;
	localparam int unsigned SCAN_LEN = MAX_VERTICES + 2;
	localparam int unsigned KW  = $clog2(SCAN_LEN + 1);
	localparam int unsigned DRAIN_LEN = 3;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_SCAN, S_PICK, S_EDGE, S_DRAIN, S_OUT
	} state_t;

	state_t         state_q;
	logic [6:0]     vc_q;
	logic [EW-1:0]  total_q;
	logic [EW-1:0]  e_q;
	logic [CW-1:0]  round_q;
	logic [CW-1:0]  o_q;
	logic [KW-1:0]  cnt_q;
	logic           start_ok_q;
	logic [DW-1:0]  pick_dist_q;
	logic [VW-1:0]  pick_q;
	logic           rd_s1;
	ctl_t           ctl_q;

	logic [CW-1:0]  nv;
	logic           accept;
	logic           add_ok;
	logic           mem_we;
	logic [MW-1:0]  mem_wdata;
	logic           mem_re;
	logic [MW-1:0]  mem_rdata;
	logic [5:0]     rd_src;
	logic [5:0]     rd_dst;
	logic [WEIGHT_BITS-1:0] rd_wt;
	logic           out_load;
	logic [XW-1:0]  out_dist_x;

	tok_t           tok [MAX_VERTICES+1];
	logic [DW-1:0]  dist_a  [MAX_VERTICES];
	logic           reach_a [MAX_VERTICES];

	always_comb begin
		if (vc_q == 7'd0) begin
			nv = CW'(1);
		end else if (CW'(vc_q) > CW'(MAX_VERTICES)) begin
			nv = CW'(MAX_VERTICES);
		end else begin
			nv = CW'(vc_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign add_ok    = (CW'(from_vertex) < nv) && (CW'(to_vertex) < nv) &&
		(total_q < EW'(MAX_EDGES));
	assign mem_we    = accept && (operation == OP_ADD) && add_ok;
	assign mem_wdata = {from_vertex, to_vertex, edge_weight_in[WEIGHT_BITS-1:0]};
	assign mem_re    = (state_q == S_EDGE);
	assign rd_src    = mem_rdata[MW-1 -: 6];
	assign rd_dst    = mem_rdata[MW-7 -: 6];
	assign rd_wt     = mem_rdata[WEIGHT_BITS-1:0];
	assign out_load  = (state_q == S_OUT) && (!out_valid || !out_stall);

	sssp_edge_mem #(.AW(AW), .DW(MW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (total_q[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (e_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	assign tok[0] = '0;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		sssp_cell #(.IDX(g), .DW(DW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.active  (CW'(g) < nv),
			.ctl     (ctl_q),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.best    (dist_a[g]),
			.reach   (reach_a[g])
		);
	end

	assign out_dist_x = XW'(dist_a[o_q[VW-1:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vc_q         <= 7'd64;
			total_q      <= '0;
			e_q          <= '0;
			round_q      <= '0;
			o_q          <= '0;
			cnt_q        <= '0;
			start_ok_q   <= 1'b0;
			pick_dist_q  <= '0;
			pick_q       <= '0;
			rd_s1        <= 1'b0;
			ctl_q        <= '0;
			out_valid    <= 1'b0;
			vertex_index <= '0;
			distance     <= '0;
			reachable    <= 1'b0;
			last_vertex  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vc_q <= cfg_data;
			end
			ctl_q.init  <= accept && (operation == OP_RUN);
			ctl_q.visit <= (state_q == S_PICK) && tok[MAX_VERTICES].found;
			rd_s1       <= mem_re;
			// relax stage: one edge from the store per cycle
			ctl_q.relax <= rd_s1 && (CW'(rd_src) == CW'(pick_q)) && (CW'(rd_dst) < nv);
			ctl_q.dst   <= VMAX_W'(rd_dst);
			ctl_q.cand  <= DMAX_W'(pick_dist_q + DW'(rd_wt));
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_ADD: begin
								if (add_ok) begin
									total_q <= total_q + EW'(1);
								end
							end
							OP_CLEAR: begin
								total_q <= '0;
							end
							OP_RUN: begin
								ctl_q.start_idx <= VMAX_W'(start_vertex);
								ctl_q.start_ok  <= CW'(start_vertex) < nv;
								start_ok_q      <= CW'(start_vertex) < nv;
								round_q         <= '0;
								state_q         <= S_CHECK;
							end
							default: begin
							end
						endcase
					end
				end
				S_CHECK: begin
					if (!start_ok_q || (round_q + CW'(1) >= nv)) begin
						o_q     <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// let a fresh token walk the whole chain
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(SCAN_LEN)) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (!tok[MAX_VERTICES].found) begin
						o_q     <= '0;
						state_q <= S_OUT;
					end else begin
						ctl_q.pick  <= tok[MAX_VERTICES].idx;
						pick_q      <= tok[MAX_VERTICES].idx[VW-1:0];
						pick_dist_q <= tok[MAX_VERTICES].dval[DW-1:0];
						e_q         <= '0;
						cnt_q       <= '0;
						state_q     <= (total_q == '0) ? S_DRAIN : S_EDGE;
					end
				end
				S_EDGE: begin
					e_q <= e_q + EW'(1);
					if (e_q + EW'(1) == total_q) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(DRAIN_LEN)) begin
						round_q <= round_q + CW'(1);
						state_q <= S_CHECK;
					end
				end
				S_OUT: begin
					if (out_load) begin
						vertex_index <= o_q[5:0];
						reachable    <= reach_a[o_q[VW-1:0]];
						distance     <= reach_a[o_q[VW-1:0]] ? out_dist_x[21:0] : 22'd0;
						last_vertex  <= (o_q + CW'(1) == nv);
						o_q          <= o_q + CW'(1);
						if (o_q + CW'(1) == nv) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[dv/single_source_shortest_path_tb.sv]
`default_nettype none
module single_source_shortest_path_tb;
	import sssp_pkg::*;

	localparam int unsigned NV_MAX  = 64;
	localparam int unsigned EDGE_CAP = 1024;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct {
		logic [5:0]  vidx;
		logic [21:0] dval;
		logic        reach;
		logic        last;
	} dist_result_t;

	class distance_board;
		dist_result_t expected_dist[$];
		logic [5:0]   e_src[EDGE_CAP];
		logic [5:0]   e_dst[EDGE_CAP];
		logic [15:0]  e_wt[EDGE_CAP];
		int unsigned  edge_count;
		logic [6:0]   nv_reg;
		int unsigned  errors;
		int unsigned  runs;
		int unsigned  matched;

		function new();
			edge_count = 0;
			nv_reg = 7'd64;
			errors = 0;
			runs = 0;
			matched = 0;
		endfunction

		function void set_count(logic [6:0] v);
			nv_reg = v;
		endfunction

		function int unsigned eff_count();
			if (nv_reg == 0) return 1;
			if (nv_reg > NV_MAX) return NV_MAX;
			return nv_reg;
		endfunction

		function void note_request(logic [1:0] op, logic [5:0] fv, logic [5:0] tv,
				logic [15:0] wt, logic [5:0] sv);
			int unsigned nv, pick, t, cand;
			int unsigned best[NV_MAX];
			bit          seen[NV_MAX];
			bit          done[NV_MAX];
			bit          found;
			dist_result_t r;
			nv = eff_count();
			case (op)
				OP_ADD: begin
					if (fv < nv && tv < nv && edge_count < EDGE_CAP) begin
						e_src[edge_count] = fv;
						e_dst[edge_count] = tv;
						e_wt[edge_count]  = wt;
						edge_count++;
					end
				end
				OP_CLEAR: edge_count = 0;
				OP_RUN: begin
					runs++;
					for (int i = 0; i < NV_MAX; i++) begin
						best[i] = 0;
						seen[i] = 0;
						done[i] = 0;
					end
					if (sv < nv) begin
						seen[sv] = 1;
						for (int rnd = 0; rnd + 1 < nv; rnd++) begin
							found = 0;
							pick = 0;
							for (int i = 0; i < nv; i++)
								if (!done[i] && seen[i] && (!found || best[i] < best[pick])) begin
									found = 1;
									pick = i;
								end
							if (!found) break;
							done[pick] = 1;
							for (int e = 0; e < edge_count; e++) begin
								t = e_dst[e];
								if (e_src[e] != pick || t >= nv || done[t]) continue;
								cand = best[pick] + e_wt[e];
								if (!seen[t] || cand < best[t]) begin
									best[t] = cand;
									seen[t] = 1;
								end
							end
						end
					end
					for (int i = 0; i < nv; i++) begin
						r.vidx  = i[5:0];
						r.dval  = seen[i] ? best[i][21:0] : 22'd0;
						r.reach = seen[i];
						r.last  = (i + 1 == nv);
						expected_dist.insert(expected_dist.size(), r);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [5:0] vidx, logic [21:0] dval, logic reach,
				logic last);
			dist_result_t x;
			if (expected_dist.size() == 0) begin
				$error("unexpected result for vertex %0d", vidx);
				errors++;
				return;
			end
			x = expected_dist.pop_front();
			if (vidx !== x.vidx) begin
				$error("vertex_index expected %0d actual %0d", x.vidx, vidx);
				errors++;
			end
			if (dval !== x.dval) begin
				$error("distance expected %0d actual %0d", x.dval, dval);
				errors++;
			end
			if (reach !== x.reach) begin
				$error("reachable expected %0d actual %0d", x.reach, reach);
				errors++;
			end
			if (last !== x.last) begin
				$error("last_vertex expected %0d actual %0d", x.last, last);
				errors++;
			end
			matched++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_NONE;
	logic [5:0]  from_vertex = '0;
	logic [5:0]  to_vertex = '0;
	logic [15:0] edge_weight_in = '0;
	logic [5:0]  start_vertex = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  vertex_index;
	logic [21:0] distance;
	logic        reachable;
	logic        last_vertex;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	distance_board board;
	bit          gaps_on = 1'b1;
	int unsigned sent = 0;

	single_source_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .from_vertex(from_vertex), .to_vertex(to_vertex),
		.edge_weight_in(edge_weight_in), .start_vertex(start_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_index(vertex_index), .distance(distance),
		.reachable(reachable), .last_vertex(last_vertex),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_request(operation, from_vertex, to_vertex, edge_weight_in,
				start_vertex);
		if (arst_n && out_valid && !out_stall)
			board.check_result(vertex_index, distance, reachable, last_vertex);
	end

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 29);

	task automatic send_request(logic [1:0] op, logic [5:0] fv, logic [5:0] tv,
			logic [15:0] wt, logic [5:0] sv);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= op;
		from_vertex <= fv;
		to_vertex <= tv;
		edge_weight_in <= wt;
		start_vertex <= sv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic add_edge(logic [5:0] fv, logic [5:0] tv, logic [15:0] wt);
		send_request(OP_ADD, fv, tv, wt, 6'($urandom));
	endtask

	task automatic run_from(logic [5:0] sv);
		send_request(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom), sv);
	endtask

	// drain results, let the block settle, then write the vertex count
	task automatic write_count(logic [6:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_dist.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_count(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned nv, n;
		logic [5:0] a, b;
		board = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset count of 64, weight extremes, self loop, parallel edges
		add_edge(6'd0, 6'd63, 16'hFFFF);
		add_edge(6'd63, 6'd0, 16'h0000);
		add_edge(6'd0, 6'd1, 16'd5);
		add_edge(6'd0, 6'd1, 16'd3);
		add_edge(6'd1, 6'd1, 16'd1);
		add_edge(6'd1, 6'd63, 16'd2);
		send_request(OP_NONE, 6'd63, 6'd63, 16'hFFFF, 6'd63);
		run_from(6'd0);
		run_from(6'd63);
		write_count(7'd8);
		add_edge(6'd9, 6'd1, 16'd4);
		add_edge(6'd2, 6'd40, 16'd4);
		add_edge(6'd2, 6'd7, 16'd10);
		run_from(6'd10);
		run_from(6'd2);
		write_count(7'd0);
		run_from(6'd0);
		write_count(7'd127);
		run_from(6'd1);
		write_count(7'd2);
		// two vertices: parallel edges, loops, an out-of-range edge drops
		send_request(OP_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0);
		add_edge(6'd0, 6'd1, 16'd7);
		add_edge(6'd1, 6'd0, 16'd2);
		add_edge(6'd0, 6'd1, 16'd3);
		add_edge(6'd1, 6'd1, 16'd9);
		add_edge(6'd2, 6'd0, 16'd1);
		run_from(6'd0);
		write_count(7'd64);
		send_request(OP_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0);
		run_from(6'd5);

		// random: mostly clear / add / run sequences, some noise
		n = 0;
		while (n < 325) begin
			gaps_on = !(n > 120 && n < 200);
			if ($urandom_range(9) < 2) begin
				case ($urandom_range(5))
					0: write_count(7'd0);
					1: write_count(7'd127);
					default: write_count(7'($urandom_range(64, 1)));
				endcase
			end
			nv = board.eff_count();
			if (nv == NV_MAX && $urandom_range(19) == 0) begin
				// longest chain of heaviest edges
				send_request(OP_CLEAR, 6'd0, 6'd0, 16'd0, 6'd0);
				for (int i = 0; i < NV_MAX - 1; i++)
					add_edge(6'(i), 6'(i + 1), 16'hFFFF);
				run_from(6'd0);
				n += NV_MAX + 1;
				continue;
			end
			if ($urandom_range(9) < 7) begin
				send_request(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom), 6'($urandom));
				n++;
			end
			repeat ($urandom_range(30)) begin
				if ($urandom_range(9) == 0) begin
					a = 6'($urandom);
					b = 6'($urandom);
				end else begin
					a = 6'($urandom_range(nv - 1));
					b = 6'($urandom_range(nv - 1));
				end
				add_edge(a, b, ($urandom_range(3) == 0) ? 16'($urandom) :
					16'($urandom_range(20)));
				n++;
				if ($urandom_range(19) == 0) begin
					send_request(OP_NONE, 6'($urandom), 6'($urandom), 16'($urandom),
						6'($urandom));
				end
			end
			run_from(($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(nv - 1)));
			n++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_dist.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d requests, %0d searches, %0d vertex results checked",
			sent, board.runs, board.matched);
		if (board.errors == 0 && board.expected_dist.size() == 0)
			$display("single_source_shortest_path_tb: PASS");
		else
			$display("single_source_shortest_path_tb: FAIL");
		$finish;
	end

	initial begin
		#200000000;
		$display("single_source_shortest_path_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

[single_source_shortest_path.f]
hw/rtl/sssp_pkg.sv
hw/rtl/sssp_edge_mem.sv
hw/rtl/sssp_cell.sv
hw/rtl/single_source_shortest_path.sv
dv/single_source_shortest_path_tb.sv
